// File: hdl/prsd_pkg.sv
// ----------------------------------------------------------------------------
// prsd_pkg
// shared types and constants of the run-length scanline decoder
// ----------------------------------------------------------------------------
package prsd_pkg;

	// most bytes per pixel that the staging registers hold
	localparam int MAX_CHANNELS = 4;
	// bits of the channel index into the staging registers
	localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	// pixel bytes carried by one result
	localparam int OUT_CHANNELS = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNELS    = 2'd0,
		CFG_LINE_PIXELS = 2'd1,
		CFG_BIG_ENDIAN  = 2'd2
	} cfg_reg_t;

	// header codes
	localparam logic [7:0] HDR_LONG_RUN = 8'd128;
	localparam logic [7:0] HDR_RUN_BIAS = 8'd127;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_COUNT_A = 2'd1,
		PH_COUNT_B = 2'd2,
		PH_PIXEL   = 2'd3
	} phase_t;

endpackage

// File: hdl/pic_rle_scanline_decoder_top.sv
// ----------------------------------------------------------------------------
// pic_rle_scanline_decoder_top
// run-length scanline decoder: compressed bytes in, pixel runs out
// ----------------------------------------------------------------------------
// a result is registered and presented in the cycle after the byte that causes it is taken
// throughput: one compressed byte per cycle while the output is not stalled;
//   a stalled output holds one result, and the next byte is taken as soon
//   as the output register frees
// reset (arst_n low, asynchronous): registers return to channels 4,
//   line_pixels 1, big-endian counts; decoder awaits a header, no result held
module pic_rle_scanline_decoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [prsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prsd_pkg::CFG_DATA_W-1:0] cfg_data,
	// compressed byte stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] input_byte
	input  logic                           s_axis_tlast,  // last_byte
	// decoded pixel runs
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] pixel_c0, [15:8] pixel_c1, [23:16] pixel_c2, [31:24] pixel_c3,
	// [47:32] repeat_count
	output logic [47:0]                    m_axis_tdata,
	output logic                           m_axis_tlast,  // line_done
	output logic                           m_axis_tuser   // [0] truncated
);
	import prsd_pkg::*;

	// configuration registers
	logic [2:0]  channels_q;
	logic [15:0] line_pixels_q;
	logic        big_endian_q;

	// decoder state
	phase_t              phase_q;
	logic [15:0]         pkt_rem_q;
	logic                repeat_q;
	logic [7:0]          count_first_q;
	logic [CH_IDX_W-1:0] ch_idx_q;
	logic [7:0]          staging_q [MAX_CHANNELS];
	logic [15:0]         pixels_left_q;

	// next state
	phase_t              phase_nxt;
	phase_t              phase_step;  // phase before an end-of-stream restart
	logic [15:0]         pkt_rem_nxt;
	logic                repeat_nxt;
	logic [7:0]          count_first_nxt;
	logic [CH_IDX_W-1:0] ch_idx_nxt;
	logic [15:0]         pixels_left_nxt;

	// result register
	logic        out_valid_q;
	logic [47:0] out_data_q;
	logic        out_done_q;
	logic        out_trunc_q;

	logic        s_accept;
	logic        cfg_accept;

	// transactions
	assign cfg_ready     = 1'b1;
	assign cfg_accept    = cfg_valid & cfg_ready;
	// the next byte goes in whenever the result register is free or drains now
	assign s_axis_tready = ~out_valid_q | m_axis_tready;
	assign s_accept      = s_axis_tvalid & s_axis_tready;

	// effective channel count, clamped to 1..MAX_CHANNELS
	localparam logic [3:0] MAX_CH_L = 4'(MAX_CHANNELS);
	logic [3:0] eff_ch;
	always_comb begin
		if (channels_q == 3'd0) begin
			eff_ch = 4'd1;
		end else if ({1'b0, channels_q} > MAX_CH_L) begin
			eff_ch = MAX_CH_L;
		end else begin
			eff_ch = {1'b0, channels_q};
		end
	end

	// pixel completion and run clipping
	logic        in_pixel;
	logic        pix_end;
	logic [15:0] run_cnt;
	logic [15:0] pixels_after;
	logic [15:0] pkt_after;
	logic        emit;

	assign in_pixel = (phase_q == PH_PIXEL);
	assign pix_end  = ((4'(ch_idx_q) + 4'd1) >= eff_ch);

	always_comb begin
		if (repeat_q) begin
			run_cnt   = (pkt_rem_q < pixels_left_q) ? pkt_rem_q : pixels_left_q;
			pkt_after = 16'd0;
		end else begin
			run_cnt   = {15'd0, (pixels_left_q != 16'd0)};
			pkt_after = pkt_rem_q - 16'd1;
		end
	end

	assign pixels_after = pixels_left_q - run_cnt;
	assign emit         = in_pixel & pix_end & (run_cnt != 16'd0);

	// next state
	always_comb begin
		phase_step      = phase_q;
		pkt_rem_nxt     = pkt_rem_q;
		repeat_nxt      = repeat_q;
		count_first_nxt = count_first_q;
		ch_idx_nxt      = ch_idx_q;
		pixels_left_nxt = pixels_left_q;
		unique case (phase_q)
			PH_COUNT_A: begin
				count_first_nxt = s_axis_tdata;
				phase_step      = PH_COUNT_B;
			end
			PH_COUNT_B: begin
				pkt_rem_nxt = big_endian_q ? {count_first_q, s_axis_tdata}
				                           : {s_axis_tdata, count_first_q};
				ch_idx_nxt  = '0;
				phase_step  = PH_PIXEL;
			end
			PH_PIXEL: begin
				if (pix_end) begin
					ch_idx_nxt      = '0;
					pkt_rem_nxt     = pkt_after;
					pixels_left_nxt = pixels_after;
					if (pkt_after == 16'd0) begin
						phase_step = PH_HEADER;
						// line finished: the next packet starts a fresh line
						if (pixels_after == 16'd0) begin
							pixels_left_nxt = line_pixels_q;
						end
					end
				end else begin
					ch_idx_nxt = ch_idx_q + CH_IDX_W'(1);
				end
			end
			PH_HEADER: begin
				ch_idx_nxt = '0;
				if (s_axis_tdata < HDR_LONG_RUN) begin
					repeat_nxt  = 1'b0;
					pkt_rem_nxt = {8'd0, s_axis_tdata} + 16'd1;
					phase_step  = PH_PIXEL;
				end else if (s_axis_tdata == HDR_LONG_RUN) begin
					repeat_nxt = 1'b1;
					phase_step = PH_COUNT_A;
				end else begin
					repeat_nxt  = 1'b1;
					pkt_rem_nxt = {8'd0, s_axis_tdata - HDR_RUN_BIAS};
					phase_step  = PH_PIXEL;
				end
			end
			default: begin
				phase_step = PH_HEADER;
			end
		endcase
		phase_nxt = phase_step;
		// end of stream restarts the decoder
		if (s_axis_tlast) begin
			phase_nxt       = PH_HEADER;
			pkt_rem_nxt     = 16'd0;
			repeat_nxt      = 1'b0;
			ch_idx_nxt      = '0;
			pixels_left_nxt = line_pixels_q;
		end
	end

	// pixel bytes as seen this cycle, the incoming byte merged in
	logic [7:0] cur_pix [OUT_CHANNELS];
	for (genvar j = 0; j < OUT_CHANNELS; j++) begin : g_out_ch
		if (j < MAX_CHANNELS) begin : g_used
			always_comb begin
				if (4'(j) >= eff_ch) begin
					cur_pix[j] = 8'd0;
				end else if (in_pixel && (ch_idx_q == CH_IDX_W'(j))) begin
					cur_pix[j] = s_axis_tdata;
				end else begin
					cur_pix[j] = staging_q[j];
				end
			end
		end else begin : g_unused
			assign cur_pix[j] = 8'd0;
		end
	end

	// result fields
	logic        res_have;
	logic [47:0] res_data;
	logic        res_done;
	logic        res_trunc;
	always_comb begin
		res_have  = emit | s_axis_tlast;
		res_trunc = s_axis_tlast & (phase_step != PH_HEADER);
		if (emit) begin
			res_data = {run_cnt, cur_pix[3], cur_pix[2], cur_pix[1], cur_pix[0]};
			res_done = (pixels_after == 16'd0);
		end else begin
			// status-only result
			res_data = '0;
			res_done = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q    <= 3'd4;
			line_pixels_q <= 16'd1;
			big_endian_q  <= 1'b1;
		end else if (cfg_accept) begin
			unique case (cfg_index)
				CFG_CHANNELS:    channels_q    <= cfg_data[2:0];
				CFG_LINE_PIXELS: line_pixels_q <= cfg_data;
				CFG_BIG_ENDIAN:  big_endian_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			pkt_rem_q     <= 16'd0;
			repeat_q      <= 1'b0;
			count_first_q <= 8'd0;
			ch_idx_q      <= '0;
		end else if (s_accept) begin
			phase_q       <= phase_nxt;
			pkt_rem_q     <= pkt_rem_nxt;
			repeat_q      <= repeat_nxt;
			count_first_q <= count_first_nxt;
			ch_idx_q      <= ch_idx_nxt;
		end
	end

	// pixels left in the line, reloaded at once by a line_pixels write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= 16'd1;
		end else if (cfg_accept && (cfg_index == CFG_LINE_PIXELS)) begin
			pixels_left_q <= cfg_data;
		end else if (s_accept) begin
			pixels_left_q <= pixels_left_nxt;
		end
	end

	// staging of pixel bytes
	for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				staging_q[k] <= 8'd0;
			end else if (s_accept && in_pixel && (ch_idx_q == CH_IDX_W'(k))) begin
				staging_q[k] <= s_axis_tdata;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			out_valid_q <= res_have;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_data_q  <= res_data;
			out_done_q  <= res_done;
			out_trunc_q <= res_trunc;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_done_q;
	assign m_axis_tuser  = out_trunc_q;

	// checks
	a_left_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pixels_left_q <= line_pixels_q)
		else $error("pixels left exceeds line length");

	a_status_only_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[47:32] == 16'd0))
			|-> (m_axis_tdata[31:0] == 32'd0) && !m_axis_tlast)
		else $error("status-only result carries pixel data or line end");

	a_count_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && (phase_q == PH_COUNT_A) && !s_axis_tlast)
			|=> (phase_q == PH_COUNT_B))
		else $error("long count byte order lost");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_axis_tlast)
			|=> (phase_q == PH_HEADER) && m_axis_tvalid && (ch_idx_q == '0))
		else $error("end of stream without result or restart");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty result register");

endmodule

// File: verif/pic_rle_scanline_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pic_rle_scanline_decoder_top_tb
// drives compressed byte streams into the scanline decoder under random
// flow control and checks every pixel run against a local decoder model
// ----------------------------------------------------------------------------
module pic_rle_scanline_decoder_top_tb;

	import prsd_pkg::*;

	// one compressed byte as it sits in the send queue
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} comp_byte_t;

	// one decoded pixel run, in the order of the output fields
	typedef struct packed {
		logic [3:0][7:0] px;
		logic [15:0]     count;
		logic            done;
		logic            trunc;
	} pix_run_t;

	localparam int SEGMENTS     = 7;
	localparam int SEG_BYTES    = 255;
	localparam int DRAIN_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_reg_t    cfg_index = CFG_CHANNELS;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;  // [7:0] input_byte
	logic        s_axis_tlast = 1'b0;  // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] pixel_c0, [15:8] pixel_c1, [23:16] pixel_c2, [31:24] pixel_c3,
	// [47:32] repeat_count
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;  // line_done
	logic        m_axis_tuser;  // [0] truncated

	pic_rle_scanline_decoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// register copies
	logic [2:0]  reg_channels;
	logic [15:0] reg_line;
	logic        reg_big_endian;

	// decoder model state
	phase_t      dec_phase;
	logic [15:0] dec_pkt_left;
	logic        dec_repeat;
	logic [7:0]  dec_count_byte;
	int unsigned dec_ch_idx;
	logic [7:0]  dec_stage [MAX_CHANNELS];
	logic [15:0] dec_px_left;

	comp_byte_t  byte_q [$];
	pix_run_t    run_q [$];
	pix_run_t    got_run;
	pix_run_t    want_run;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_queued = 0;
	int n_bytes = 0;
	int n_runs = 0;
	int n_status = 0;
	int errors = 0;

	function automatic int unsigned eff_channels();
		if (reg_channels == 0) return 1;
		if (reg_channels > MAX_CHANNELS) return MAX_CHANNELS;
		return 32'(reg_channels);
	endfunction

	// end of stream or reset: back to header parsing with a fresh line
	function automatic void restart_decoder();
		dec_phase = PH_HEADER;
		dec_pkt_left = '0;
		dec_repeat = 1'b0;
		dec_ch_idx = 0;
		dec_px_left = reg_line;
	endfunction

	// advance the decoder model by one compressed byte; returns 1 with a run
	function automatic bit decode_byte(input logic [7:0] b, input logic lst,
			output pix_run_t run);
		int unsigned eff;
		int unsigned cnt;
		bit have;
		run = '0;
		have = 1'b0;
		eff = eff_channels();
		case (dec_phase)
			PH_COUNT_A: begin
				dec_count_byte = b;
				dec_phase = PH_COUNT_B;
			end
			PH_COUNT_B: begin
				dec_pkt_left = reg_big_endian ? {dec_count_byte, b} : {b, dec_count_byte};
				dec_ch_idx = 0;
				dec_phase = PH_PIXEL;
			end
			PH_PIXEL: begin
				if (dec_ch_idx < MAX_CHANNELS) dec_stage[dec_ch_idx] = b;
				// a pixel is complete once the index reaches the last channel
				if (dec_ch_idx + 1 >= eff) begin
					dec_ch_idx = 0;
					if (dec_repeat) begin
						// runs are clipped to the pixels left in the line
						cnt = 32'((dec_pkt_left < dec_px_left) ? dec_pkt_left : dec_px_left);
						dec_pkt_left = '0;
					end else begin
						// raw pixels past the end of the line are swallowed
						cnt = (dec_px_left != 0) ? 1 : 0;
						dec_pkt_left = dec_pkt_left - 16'd1;
					end
					if (cnt > 0) begin
						dec_px_left = dec_px_left - 16'(cnt);
						for (int j = 0; j < OUT_CHANNELS; j++)
							run.px[j] = (j < eff) ? dec_stage[j] : 8'h00;
						run.count = 16'(cnt);
						run.done = (dec_px_left == 0);
						have = 1'b1;
					end
					if (dec_pkt_left == 0) begin
						dec_phase = PH_HEADER;
						if (dec_px_left == 0) dec_px_left = reg_line;
					end
				end else begin
					dec_ch_idx++;
				end
			end
			default: begin
				dec_ch_idx = 0;
				if (b < HDR_LONG_RUN) begin
					dec_repeat = 1'b0;
					dec_pkt_left = 16'(b) + 16'd1;
					dec_phase = PH_PIXEL;
				end else if (b == HDR_LONG_RUN) begin
					dec_repeat = 1'b1;
					dec_phase = PH_COUNT_A;
				end else begin
					dec_repeat = 1'b1;
					dec_pkt_left = 16'(b - HDR_RUN_BIAS);
					dec_phase = PH_PIXEL;
				end
			end
		endcase
		// end of stream always yields a transaction, status-only if no pixel
		if (lst) begin
			run.trunc = (dec_phase != PH_HEADER);
			have = 1'b1;
			restart_decoder();
		end
		return have;
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic lst);
		byte_q.push_back('{data: b, last: lst});
		n_queued++;
	endfunction

	// one stream of mostly well-formed packets, sometimes cut short or noisy
	task automatic add_stream();
		logic [7:0]  sq [$];
		logic [15:0] cnt16;
		int unsigned eff, npkt, kind, n, pkt_start, stop, k;
		eff = eff_channels();
		npkt = $urandom_range(1, 6);
		pkt_start = 0;
		for (int p = 0; p < npkt; p++) begin
			pkt_start = sq.size();
			kind = $urandom_range(99);
			if (kind < 45) begin
				// raw packet, now and then up to the longest one
				n = ($urandom_range(49) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
				sq.push_back(8'(n - 1));
				repeat (n * eff) sq.push_back(8'($urandom));
			end else if (kind < 78) begin
				sq.push_back(8'($urandom_range(129, 255)));
				repeat (eff) sq.push_back(8'($urandom));
			end else if (kind < 95) begin
				case ($urandom_range(3))
					0: cnt16 = 16'd0;
					1: cnt16 = 16'($urandom_range(1, 40));
					2: cnt16 = 16'hffff;
					default: cnt16 = 16'($urandom);
				endcase
				sq.push_back(HDR_LONG_RUN);
				if (reg_big_endian) begin
					sq.push_back(cnt16[15:8]);
					sq.push_back(cnt16[7:0]);
				end else begin
					sq.push_back(cnt16[7:0]);
					sq.push_back(cnt16[15:8]);
				end
				repeat (eff) sq.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 3)) sq.push_back(8'($urandom));
			end
		end
		// clean end, end inside the final packet, or no end at all
		k = $urandom_range(19);
		if (k < 15) stop = sq.size() - 1;
		else if (k < 19) stop = $urandom_range(pkt_start, sq.size() - 1);
		else stop = sq.size();
		for (int i = 0; i < sq.size() && i <= stop; i++)
			push_byte(sq[i], i == stop);
	endtask

	// register write; the model copy follows at the accepting edge
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CHANNELS: reg_channels = val[2:0];
			CFG_LINE_PIXELS: begin
				reg_line = val;
				dec_px_left = val;
			end
			default: reg_big_endian = val[0];
		endcase
		@(negedge clk);
	endtask

	// sender holds off until the queue is empty and every run is back
	task automatic wait_drained();
		do @(negedge clk); while (byte_q.size() != 0 || s_axis_tvalid || run_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	// byte driver: tvalid only drops once the current transaction has gone
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				n_bytes++;
				if (decode_byte(s_axis_tdata, s_axis_tlast, got_run)) run_q.push_back(got_run);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					{s_axis_tdata, s_axis_tlast} <= byte_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// run monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (run_q.size() == 0) begin
					$error("pixel run transaction with nothing expected");
					errors++;
				end else begin
					want_run = run_q.pop_front();
					if (want_run.count == 0) n_status++;
					else n_runs++;
					for (int j = 0; j < OUT_CHANNELS; j++) begin
						if (m_axis_tdata[8*j +: 8] !== want_run.px[j]) begin
							$error("pixel_c%0d mismatch: expected %0d, actual %0d",
								j, want_run.px[j], m_axis_tdata[8*j +: 8]);
							errors++;
						end
					end
					if (m_axis_tdata[47:32] !== want_run.count) begin
						$error("repeat_count mismatch: expected %0d, actual %0d",
							want_run.count, m_axis_tdata[47:32]);
						errors++;
					end
					if (m_axis_tlast !== want_run.done) begin
						$error("line_done mismatch: expected %0d, actual %0d",
							want_run.done, m_axis_tlast);
						errors++;
					end
					if (m_axis_tuser !== want_run.trunc) begin
						$error("truncated mismatch: expected %0d, actual %0d",
							want_run.trunc, m_axis_tuser);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d runs outstanding", run_q.size());
		$display("pic_rle_scanline_decoder_top_tb failed");
		$finish;
	end

	initial begin
		logic [2:0]  seg_ch   [SEGMENTS] = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd2, 3'd1, 3'd4};
		logic [15:0] seg_line [SEGMENTS] = '{16'd20, 16'hffff, 16'd1, 16'd7, 16'd0, 16'd13, 16'd3};
		logic        seg_be   [SEGMENTS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		int target;
		reg_channels = 3'd4;
		reg_line = 16'd1;
		reg_big_endian = 1'b1;
		dec_count_byte = '0;
		foreach (dec_stage[i]) dec_stage[i] = '0;
		restart_decoder();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: one byte per pixel, five-pixel line, high byte first
		send_idle_pct = 11;
		recv_stall_pct = 71;
		write_reg(CFG_CHANNELS, 16'd1);
		write_reg(CFG_LINE_PIXELS, 16'd5);
		write_reg(CFG_BIG_ENDIAN, 16'd1);
		push_byte(8'h00, 1'b0);  // shortest raw packet
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);  // longest short run, clipped at line end
		push_byte(8'h00, 1'b0);
		push_byte(HDR_LONG_RUN, 1'b0);  // long run of three
		push_byte(8'h00, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'ha5, 1'b0);
		push_byte(HDR_LONG_RUN, 1'b0);  // long count of zero, no pixel
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h5a, 1'b0);
		push_byte(8'h02, 1'b0);  // line ends inside a raw packet
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'h81, 1'b0);  // clean end of stream on a pixel
		push_byte(8'h7f, 1'b1);
		push_byte(8'h05, 1'b0);  // stream ends inside a raw packet
		push_byte(8'hc3, 1'b1);
		push_byte(HDR_LONG_RUN, 1'b1);  // ends before the count: status only
		push_byte(8'h00, 1'b1);  // ends on a bare header
		wait_drained();

		// random segments, one register setting each
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s < 2) begin
				send_idle_pct = 11;
				recv_stall_pct = 71;
			end else if (s < 4) begin
				send_idle_pct = 71;
				recv_stall_pct = 11;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			// channel count with junk in the unused upper bits
			write_reg(CFG_CHANNELS, {13'($urandom), seg_ch[s]});
			write_reg(CFG_LINE_PIXELS, seg_line[s]);
			write_reg(CFG_BIG_ENDIAN, {15'd0, seg_be[s]});
			target = n_queued + SEG_BYTES;
			while (n_queued < target) add_stream();
			// try to leave a pixel half staged so the next setting can land mid-pixel
			push_byte(8'h83, 1'b0);
			push_byte(8'($urandom), 1'b0);
			wait_drained();
		end

		repeat (20) @(negedge clk);
		$display("decoded %0d compressed bytes into %0d pixel runs and %0d status transactions",
			n_bytes, n_runs, n_status);
		$display("register settings covered channel counts 0 to 4 and 7, line lengths 0 to 65535, both count orders");
		if (errors == 0) begin
			$display("pic_rle_scanline_decoder_top_tb passed");
		end else begin
			$display("pic_rle_scanline_decoder_top_tb failed");
		end
		$finish;
	end

endmodule
